/* rtl/core/ssdf_pkg.sv */
// Shared constants, saturating arithmetic and min/max helpers for the socket distance evaluator.
package ssdf_pkg;

  localparam int unsigned SQRT_STAGES = 16;
  localparam int unsigned HYPOT_LAT   = SQRT_STAGES + 3;
  localparam int unsigned CFG_IDX_W   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_HEIGHT      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_RADIUS      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_HEIGHT       = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_OUTER_RADIUS = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_INNER_RADIUS = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOLE_RADIUS        = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HOLE_HEIGHT        = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HOLE_OFFSET        = 4'd7;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? S32_MIN : S32_MAX;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat33({a[31], a} + {b[31], b});
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat33({a[31], a} - {b[31], b});
  endfunction

  function automatic logic signed [31:0] abs_sat(input logic signed [31:0] a);
    return a[31] ? sub_sat(32'sd0, a) : a;
  endfunction

  function automatic logic signed [31:0] smax(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [31:0] smin(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

/* rtl/core/ssdf_hypot.sv */
// Pipelined floor(sqrt(a*a + b*b)) with saturation to the signed 32-bit range.
module ssdf_hypot (
  input  logic                                clk_i,
  input  logic [ssdf_pkg::HYPOT_LAT-1:0]      en_i,
  input  logic signed [31:0]                  a_i,
  input  logic signed [31:0]                  b_i,
  output logic signed [31:0]                  len_o
);

  localparam int unsigned NS = ssdf_pkg::SQRT_STAGES;

  logic [31:0] abs_a_q, abs_b_q;
  logic [63:0] sq_a_q, sq_b_q, sum_q;
  logic [63:0] rad_q  [NS];
  logic [35:0] rem_q  [NS];
  logic [31:0] root_q [NS];
  logic [63:0] rad_d  [NS];
  logic [35:0] rem_d  [NS];
  logic [31:0] root_d [NS];

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    logic [63:0] rad_in;
    logic [35:0] rem_in;
    logic [31:0] root_in;
    if (k == 0) begin : g_first
      assign rad_in  = sum_q;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    always_comb begin
      logic [63:0] rad;
      logic [35:0] rem;
      logic [31:0] root;
      logic [35:0] trial;
      rad  = rad_in;
      rem  = rem_in;
      root = root_in;
      for (int j = 0; j < 2; j++) begin
        rem   = {rem[33:0], rad[63:62]};
        rad   = {rad[61:0], 2'b00};
        trial = {2'b00, root, 2'b01};
        if (rem >= trial) begin
          rem  = rem - trial;
          root = {root[30:0], 1'b1};
        end else begin
          root = {root[30:0], 1'b0};
        end
      end
      rad_d[k]  = rad;
      rem_d[k]  = rem;
      root_d[k] = root;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      abs_a_q <= a_i[31] ? (~a_i + 32'd1) : a_i;
      abs_b_q <= b_i[31] ? (~b_i + 32'd1) : b_i;
    end
    if (en_i[1]) begin
      sq_a_q <= {32'd0, abs_a_q} * {32'd0, abs_a_q};
      sq_b_q <= {32'd0, abs_b_q} * {32'd0, abs_b_q};
    end
    if (en_i[2]) begin
      sum_q <= sq_a_q + sq_b_q;
    end
    for (int k = 0; k < NS; k++) begin
      if (en_i[3+k]) begin
        rad_q[k]  <= rad_d[k];
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
      end
    end
  end

  assign len_o = root_q[NS-1][31] ? ssdf_pkg::S32_MAX : root_q[NS-1];

endmodule

/* rtl/core/socket_shape_sdf_eval.sv */
// Socket shape signed-distance evaluator: top level.
// One query point (point_x/y/z, signed fixed point with FRAC_BITS fraction bits) goes in per
// cycle while in_ready_o is high, and one signed distance comes out per point, in order. The
// pipe depth comes mostly from two chained banks of hypotenuse units (three, then four), each
// a 19-stage pipe (abs, square, sum, 16 square-root stages of two result bits each). Stages
// advance independently, so empty slots close up while the output waits. The user must write
// configuration registers through the cfg port only while the pipe holds no point; the block
// itself does not enforce this. Every write is taken at once; indexes above 7 are ignored.
module socket_shape_sdf_eval #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ssdf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [31:0]                      cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [31:0]               point_x_i,
  input  logic signed [31:0]               point_y_i,
  input  logic signed [31:0]               point_z_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [31:0]               signed_distance_o
);

  localparam int unsigned HL  = ssdf_pkg::HYPOT_LAT;
  localparam int unsigned DS  = HL + 1;
  localparam int unsigned CS  = 2 * HL + 2;
  localparam int unsigned US  = 2 * HL + 3;
  localparam int unsigned NST = 2 * HL + 5;
  localparam logic signed [31:0] MinusOne = -(32'sd1 <<< FRAC_BITS);

  logic [30:0]        bottom_height_q, bottom_radius_q, upper_height_q;
  logic [30:0]        upper_outer_radius_q, upper_inner_radius_q;
  logic [30:0]        hole_radius_q, hole_height_q;
  logic signed [31:0] hole_offset_q;

  logic signed [31:0] bh, br, uh, uo, hr, thick, hh;

  logic [NST-1:0] v_q;
  logic [NST-1:0] en;

  logic signed [31:0] s0_x_q, s0_y_q, s0_yl_q, s0_yr_q, s0_apz_q, s0_azs_q;
  logic signed [31:0] dl_apz_q [HL];
  logic signed [31:0] dl_azs_q [HL];

  logic signed [31:0] hyp_a, hyp_l, hyp_r;
  logic signed [31:0] d0_q [4];
  logic signed [31:0] d1_q [4];
  logic signed [31:0] inner_q [HL][4];
  logic signed [31:0] hyp2 [4];
  logic signed [31:0] cyl_q [4];
  logic signed [31:0] upper_q, bottom_q, holes_q, dist_q;
  logic signed [31:0] shell;

  assign bh    = {1'b0, bottom_height_q};
  assign br    = {1'b0, bottom_radius_q};
  assign uh    = {1'b0, upper_height_q};
  assign uo    = {1'b0, upper_outer_radius_q};
  assign hr    = {1'b0, hole_radius_q};
  assign thick = ssdf_pkg::sub_sat(uo, {1'b0, upper_inner_radius_q});
  assign hh    = ssdf_pkg::add_sat({1'b0, hole_height_q}, bh);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bottom_height_q      <= '0;
      bottom_radius_q      <= '0;
      upper_height_q       <= '0;
      upper_outer_radius_q <= '0;
      upper_inner_radius_q <= '0;
      hole_radius_q        <= '0;
      hole_height_q        <= '0;
      hole_offset_q        <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ssdf_pkg::REG_BOTTOM_HEIGHT:      bottom_height_q      <= cfg_data_i[30:0];
        ssdf_pkg::REG_BOTTOM_RADIUS:      bottom_radius_q      <= cfg_data_i[30:0];
        ssdf_pkg::REG_UPPER_HEIGHT:       upper_height_q       <= cfg_data_i[30:0];
        ssdf_pkg::REG_UPPER_OUTER_RADIUS: upper_outer_radius_q <= cfg_data_i[30:0];
        ssdf_pkg::REG_UPPER_INNER_RADIUS: upper_inner_radius_q <= cfg_data_i[30:0];
        ssdf_pkg::REG_HOLE_RADIUS:        hole_radius_q        <= cfg_data_i[30:0];
        ssdf_pkg::REG_HOLE_HEIGHT:        hole_height_q        <= cfg_data_i[30:0];
        ssdf_pkg::REG_HOLE_OFFSET:        hole_offset_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance a stage when it is empty or the stage after it advances.
  always_comb begin
    en[NST-1] = !v_q[NST-1] || out_ready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NST-1];
  assign signed_distance_o = dist_q;

  ssdf_hypot u_hyp_a (
    .clk_i (clk_i), .en_i (en[HL:1]), .a_i (s0_x_q), .b_i (s0_y_q), .len_o (hyp_a)
  );
  ssdf_hypot u_hyp_l (
    .clk_i (clk_i), .en_i (en[HL:1]), .a_i (s0_x_q), .b_i (s0_yl_q), .len_o (hyp_l)
  );
  ssdf_hypot u_hyp_r (
    .clk_i (clk_i), .en_i (en[HL:1]), .a_i (s0_x_q), .b_i (s0_yr_q), .len_o (hyp_r)
  );

  for (genvar c = 0; c < 4; c++) begin : g_cyl
    ssdf_hypot u_hyp_o (
      .clk_i (clk_i),
      .en_i  (en[2*HL+1:HL+2]),
      .a_i   (ssdf_pkg::smax(d0_q[c], 32'sd0)),
      .b_i   (ssdf_pkg::smax(d1_q[c], 32'sd0)),
      .len_o (hyp2[c])
    );
  end

  assign shell = ssdf_pkg::sub_sat(ssdf_pkg::abs_sat(cyl_q[1]), thick);

  // Cylinder order: bottom, upper, left hole, right hole.
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_x_q   <= point_x_i;
      s0_y_q   <= point_y_i;
      s0_yl_q  <= ssdf_pkg::add_sat(point_y_i, hole_offset_q);
      s0_yr_q  <= ssdf_pkg::sub_sat(point_y_i, hole_offset_q);
      s0_apz_q <= ssdf_pkg::abs_sat(point_z_i);
      s0_azs_q <= ssdf_pkg::abs_sat(ssdf_pkg::sub_sat(point_z_i, bh));
    end
    if (en[1]) begin
      dl_apz_q[0] <= s0_apz_q;
      dl_azs_q[0] <= s0_azs_q;
    end
    for (int k = 1; k < HL; k++) begin
      if (en[1+k]) begin
        dl_apz_q[k] <= dl_apz_q[k-1];
        dl_azs_q[k] <= dl_azs_q[k-1];
      end
    end
    if (en[DS]) begin
      d0_q[0] <= ssdf_pkg::sub_sat(hyp_a, br);
      d1_q[0] <= ssdf_pkg::sub_sat(dl_apz_q[HL-1], br);
      d0_q[1] <= ssdf_pkg::sub_sat(hyp_a, uo);
      d1_q[1] <= ssdf_pkg::sub_sat(dl_azs_q[HL-1], uh);
      d0_q[2] <= ssdf_pkg::sub_sat(hyp_l, hr);
      d1_q[2] <= ssdf_pkg::sub_sat(dl_azs_q[HL-1], hh);
      d0_q[3] <= ssdf_pkg::sub_sat(hyp_r, hr);
      d1_q[3] <= ssdf_pkg::sub_sat(dl_azs_q[HL-1], hh);
    end
    if (en[DS+1]) begin
      for (int c = 0; c < 4; c++) begin
        inner_q[0][c] <= ssdf_pkg::smin(ssdf_pkg::smax(d0_q[c], d1_q[c]), 32'sd0);
      end
    end
    for (int k = 1; k < HL; k++) begin
      if (en[DS+1+k]) begin
        inner_q[k] <= inner_q[k-1];
      end
    end
    if (en[CS]) begin
      for (int c = 0; c < 4; c++) begin
        cyl_q[c] <= ssdf_pkg::add_sat(inner_q[HL-1][c], hyp2[c]);
      end
    end
    if (en[US]) begin
      upper_q  <= ssdf_pkg::smax(shell, MinusOne);
      bottom_q <= cyl_q[0];
      holes_q  <= ssdf_pkg::smin(cyl_q[2], cyl_q[3]);
    end
    if (en[NST-1]) begin
      dist_q <= ssdf_pkg::smax(ssdf_pkg::sub_sat(32'sd0, holes_q),
                               ssdf_pkg::smin(upper_q, bottom_q));
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while output drains");
  a_accept_fills_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v_q[0])
    else $error("accepted word lost at first stage");
  a_hold_before_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i && v_q[NST-2]) |-> !en[NST-2])
    else $error("stage overwrote a held word");
  a_drain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !v_q[NST-2]) |=> !out_valid_o)
    else $error("word repeated at output");
`endif

endmodule
